// ===== rtl/wsfd_pkg.sv =====
// Package for the WebSocket server frame decoder.
// Field widths, result and error codes, header constants and the header check struct.
// No dependencies.
package wsfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned OPC_W   = 4;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned CFG_W   = 17;

    // Reset capacity: 65535 payload bytes plus the 4-byte extended header.
    localparam logic [CFG_W-1:0]  MAX_FRAME_RESET = 17'd65539;

    localparam logic [BYTE_W-1:0] HDR_RSV_MASK = 8'h70;
    localparam logic [6:0]        LEN_EXT16    = 7'd126;
    localparam logic [6:0]        LEN_EXT64    = 7'd127;
    localparam logic [2:0]        HDR_SHORT    = 3'd2;
    localparam logic [2:0]        HDR_EXT      = 3'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_RESERVED = 3'd0,
        ERR_MASKED   = 3'd1,
        ERR_NOT_FIN  = 3'd2,
        ERR_OPCODE0  = 3'd3,
        ERR_LEN64    = 3'd4,
        ERR_CAPACITY = 3'd5
    } t_err;

    // Result of checking the two header bytes.
    typedef struct packed {
        logic       fail;   // one of the header checks failed
        t_err       code;   // first failing check
        logic       ext;    // 16-bit extended length follows
        logic [6:0] len7;   // short length field
    } t_hdr_chk;

endpackage

// ===== rtl/wsfd_rx_if.sv =====
// Byte input channel of the frame decoder: valid/ready plus the received byte.
// Depends on wsfd_pkg.
interface wsfd_rx_if import wsfd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/wsfd_res_if.sv =====
// Result channel of the frame decoder: valid/ready plus the result word fields.
// Depends on wsfd_pkg.
interface wsfd_res_if import wsfd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [OPC_W-1:0]  frame_opcode;
    logic [LEN_W-1:0]  frame_length;
    logic              last_of_frame;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, output result_kind, output payload_byte,
                    output frame_opcode, output frame_length, output last_of_frame,
                    output error_code, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input frame_opcode, input frame_length, input last_of_frame,
                    input error_code, output ready);
endinterface

// ===== rtl/wsfd_hdr_check.sv =====
// Header checks on the two base header bytes, in priority order.
// Depends on wsfd_pkg.
module wsfd_hdr_check import wsfd_pkg::*; (
    input  logic [BYTE_W-1:0] i_hdr0,
    input  logic [BYTE_W-1:0] i_hdr1,
    output t_hdr_chk          o_chk
);

    always_comb begin
        o_chk.fail = 1'b1;
        o_chk.code = ERR_RESERVED;
        o_chk.ext  = 1'b0;
        o_chk.len7 = i_hdr1[6:0];
        if ((i_hdr0 & HDR_RSV_MASK) != '0) begin
            o_chk.code = ERR_RESERVED;
        end else if (i_hdr1[7]) begin
            o_chk.code = ERR_MASKED;
        end else if (!i_hdr0[7]) begin
            o_chk.code = ERR_NOT_FIN;
        end else if (i_hdr0[OPC_W-1:0] == '0) begin
            o_chk.code = ERR_OPCODE0;
        end else if (i_hdr1[6:0] == LEN_EXT64) begin
            o_chk.code = ERR_LEN64;
        end else begin
            o_chk.fail = 1'b0;
            o_chk.ext  = (i_hdr1[6:0] == LEN_EXT16);
        end
    end

endmodule

// ===== rtl/websocket_server_frame_decoder.sv =====
// Top level of the WebSocket server frame decoder (unmasked, unfragmented frames).
// Depends on wsfd_pkg, wsfd_rx_if, wsfd_res_if and wsfd_hdr_check.
//
// Takes the received stream one byte per word on i_rx and gives at most one result word
// per byte on o_res. The rate is one byte per clock unless o_res.ready stalls; each byte
// passes an input register and then the result register.
// Header bytes give no result; each payload byte gives a KIND_DATA word with the frame's
// opcode and length, last_of_frame marking the final byte; a zero-length frame gives one
// KIND_EMPTY word. The first protocol violation gives one KIND_ERROR word, checked in the
// order reserved bits, mask, FIN, opcode zero, 64-bit length, capacity; after it the block
// swallows every byte silently until reset. Capacity (i_cfg_wr_data, header plus payload
// bytes) resets to 65539; the user must write it only while idle; the block does not check.
module websocket_server_frame_decoder import wsfd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    wsfd_rx_if.sink          i_rx,
    wsfd_res_if.source       o_res
);

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXTHI = 3'd2,
        PH_EXTLO = 3'd3,
        PH_DATA  = 3'd4,
        PH_ERR   = 3'd5
    } t_phase;

    // control state
    t_phase            r_phase,     n_phase;
    logic              r_in_valid,  n_in_valid;
    logic              r_out_valid, n_out_valid;
    logic [CFG_W-1:0]  r_max_frame, n_max_frame;
    // frame context
    logic [OPC_W-1:0]  r_opcode,    n_opcode;
    logic [BYTE_W-1:0] r_len_hi,    n_len_hi;
    logic [LEN_W-1:0]  r_held_len,  n_held_len;
    logic [LEN_W-1:0]  r_remaining, n_remaining;
    // input byte register
    logic [BYTE_W-1:0] r_in_byte,   n_in_byte;
    // result word
    t_kind             r_kind,      n_kind;
    logic [BYTE_W-1:0] r_data,      n_data;
    logic [OPC_W-1:0]  r_out_opc,   n_out_opc;
    logic [LEN_W-1:0]  r_out_len,   n_out_len;
    logic              r_last,      n_last;
    t_err              r_err,       n_err;

    logic              out_free;     // result register can take a new word
    logic              step;         // buffered byte is processed this cycle
    logic              len_known;    // full payload length known this cycle
    logic [LEN_W-1:0]  known_len;
    logic [2:0]        known_hdr;
    logic [CFG_W-1:0]  frame_total;
    t_hdr_chk          hdr_chk;

    wsfd_hdr_check u_hdr_check (
        .i_hdr0 (r_len_hi),
        .i_hdr1 (r_in_byte),
        .o_chk  (hdr_chk)
    );

    assign out_free   = !r_out_valid || o_res.ready;
    assign step       = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;

    // Length source: short form on the second header byte, 16-bit form on its low byte.
    assign known_len   = (r_phase == PH_EXTLO) ? {r_len_hi, r_in_byte}
                                               : {{(LEN_W-7){1'b0}}, hdr_chk.len7};
    assign known_hdr   = (r_phase == PH_EXTLO) ? HDR_EXT : HDR_SHORT;
    assign frame_total = {1'b0, known_len} + {{(CFG_W-3){1'b0}}, known_hdr};

    always_comb begin
        n_phase     = r_phase;
        n_max_frame = i_cfg_wr_en ? i_cfg_wr_data : r_max_frame;
        n_opcode    = r_opcode;
        n_len_hi    = r_len_hi;
        n_held_len  = r_held_len;
        n_remaining = r_remaining;
        n_in_valid  = r_in_valid;
        n_in_byte   = r_in_byte;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_data      = r_data;
        n_out_opc   = r_out_opc;
        n_out_len   = r_out_len;
        n_last      = r_last;
        n_err       = r_err;
        len_known   = 1'b0;

        if (out_free) begin
            n_out_valid = 1'b0;
        end
        if (step) begin
            n_in_valid = 1'b0;
        end
        if (i_rx.valid && i_rx.ready) begin
            n_in_valid = 1'b1;
            n_in_byte  = i_rx.rx_byte;
        end

        if (step) begin
            // defaults of a result word; only used when n_out_valid is set
            n_data    = '0;
            n_out_opc = r_opcode;
            n_out_len = '0;
            n_last    = 1'b0;
            n_err     = ERR_RESERVED;
            case (r_phase)
                PH_HDR0: begin
                    n_len_hi = r_in_byte;
                    n_opcode = r_in_byte[OPC_W-1:0];
                    n_phase  = PH_HDR1;
                end
                PH_HDR1: begin
                    if (hdr_chk.fail) begin
                        n_phase     = PH_ERR;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_ERROR;
                        n_err       = hdr_chk.code;
                    end else if (hdr_chk.ext) begin
                        n_phase = PH_EXTHI;
                    end else begin
                        len_known = 1'b1;
                    end
                end
                PH_EXTHI: begin
                    n_len_hi = r_in_byte;
                    n_phase  = PH_EXTLO;
                end
                PH_EXTLO: begin
                    len_known = 1'b1;
                end
                PH_DATA: begin
                    n_remaining = r_remaining - 16'd1;
                    n_out_valid = 1'b1;
                    n_kind      = KIND_DATA;
                    n_data      = r_in_byte;
                    n_out_len   = r_held_len;
                    n_last      = (r_remaining <= 16'd1);
                    if (r_remaining <= 16'd1) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    // sticky error and unused codes: swallow the byte
                end
            endcase

            if (len_known) begin
                if (frame_total > r_max_frame) begin
                    n_phase     = PH_ERR;
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ERROR;
                    n_err       = ERR_CAPACITY;
                end else begin
                    n_held_len  = known_len;
                    n_remaining = known_len;
                    if (known_len == '0) begin
                        n_phase     = PH_HDR0;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_EMPTY;
                        n_last      = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_frame <= MAX_FRAME_RESET;
            r_opcode    <= '0;
            r_len_hi    <= '0;
            r_held_len  <= '0;
            r_remaining <= '0;
        end else begin
            r_phase     <= n_phase;
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_max_frame <= n_max_frame;
            r_opcode    <= n_opcode;
            r_len_hi    <= n_len_hi;
            r_held_len  <= n_held_len;
            r_remaining <= n_remaining;
        end
        r_in_byte <= n_in_byte;
        r_kind    <= n_kind;
        r_data    <= n_data;
        r_out_opc <= n_out_opc;
        r_out_len <= n_out_len;
        r_last    <= n_last;
        r_err     <= n_err;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_kind   = r_kind;
    assign o_res.payload_byte  = r_data;
    assign o_res.frame_opcode  = r_out_opc;
    assign o_res.frame_length  = r_out_len;
    assign o_res.last_of_frame = r_last;
    assign o_res.error_code    = r_err;

endmodule

// ===== rtl/wsfd_checker.sv =====
// Port-level checks for the frame decoder, bound to the top level.
// Depends on wsfd_pkg and websocket_server_frame_decoder.
module wsfd_checker import wsfd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [KIND_W-1:0] i_res_kind,
    input logic [LEN_W-1:0]  i_res_len,
    input logic              i_res_last,
    input logic [ERR_W-1:0]  i_res_err
);

    // error is sticky: nothing follows a delivered error word
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && i_res_kind == KIND_ERROR) |=> !i_res_valid)
        else $error("result after error word");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_kind == KIND_EMPTY) |-> (i_res_last && i_res_len == '0))
        else $error("empty frame word malformed");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_kind == KIND_ERROR)
            |-> (!i_res_last && i_res_len == '0 && i_res_err <= ERR_CAPACITY))
        else $error("error word malformed");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_kind == KIND_DATA) |-> (i_res_len != '0 && i_res_err == '0))
        else $error("data word with zero length");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_kind == KIND_DATA || i_res_kind == KIND_EMPTY
                         || i_res_kind == KIND_ERROR))
        else $error("unknown result kind");

endmodule

bind websocket_server_frame_decoder wsfd_checker u_wsfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.result_kind),
    .i_res_len   (o_res.frame_length),
    .i_res_last  (o_res.last_of_frame),
    .i_res_err   (o_res.error_code)
);
